FILE: src/assert_macros.svh
// Assertion macros for the block's top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a property holds on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`endif

FILE: src/dctb_pkg.sv
// Types and constants for the duty-cycle timer bank.
package dctb_pkg;
   localparam int unsigned MsPerS = 1000;

   typedef enum logic [3:0] {
      CMD_TICK = 4'd0, CMD_ADD = 4'd1, CMD_SET_ON = 4'd2, CMD_SET_CYC = 4'd3,
      CMD_SET_BOTH = 4'd4, CMD_ENABLE = 4'd5, CMD_GET_ON = 4'd6,
      CMD_GET_CYC = 4'd7, CMD_GET_EL = 4'd8, CMD_BEGIN = 4'd9
   } cmd_type;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   localparam logic CSR_DEF_ON = 1'b0;
   localparam logic CSR_DEF_CYC = 1'b1;

   typedef struct packed {
      logic [3:0] command;
      logic [1:0] channel_type;
      logic [3:0] floor_id;
      logic [22:0] on_seconds;
      logic [22:0] cycle_seconds;
      logic enable_flag;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [22:0] value_seconds;
      logic [15:0] channel_states;
   } rsp_type;

   // Seconds to milliseconds, modulo 2^32.
   function automatic logic [31:0] sec_to_ms(input logic [22:0] s);
      logic [41:0] p;
      p = {19'd0, s} * 42'd1000;
      return p[31:0];
   endfunction
endpackage

FILE: src/dctb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module dctb_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: src/dctb_div1000.sv
// Divide-by-1000 unit for 32-bit values by reciprocal multiplication, with a registered product.
module dctb_div1000 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   output logic        busy,
   output logic [22:0] quotient
);
   // 2^38 / 1000 rounded up; the product shifted by 38 is exact for every 32-bit dividend.
   localparam logic [28:0] Recip = 29'd274877907;

   logic [60:0] prod_ff;
   logic        busy_ff;

   assign busy = busy_ff;
   assign quotient = prod_ff[60:38];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start;
      end
      if (start) begin
         prod_ff <= {29'd0, dividend} * {32'd0, Recip};
      end
   end
endmodule

FILE: src/duty_cycle_timer_bank.sv
// Top level of the duty-cycle timer bank: sequencer over channel memories.
//
//   channel | ports       | moves
//   req     | req_*       | one command item
//   rsp     | rsp_*       | one result item
//   csr     | csr_*       | default times
//
// A tick reads, waits for and updates each used channel in turn; begin-all enables each
// used channel in turn; add writes one entry; a full add or an unused code goes straight out.
// Other commands scan the table one entry per cycle up to the match (or its end), then enable,
// read and update the entry, or read it and run the divider (a query); no match ends the scan.
// Reset is synchronous; times live in RAM and are written by add before use.
// The result sits in an output register; a new item waits until it is taken.
module duty_cycle_timer_bank #(
   parameter int CHANNELS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dctb_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dctb_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [31:0]         csr_data
);
   `include "assert_macros.svh"

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW = $clog2(CHANNELS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCH_W, S_RUN_RD, S_RUN_W, S_RUN_WR, S_OP_RD, S_OP_W,
      S_OP_WR, S_OP2_RD, S_OP2_W, S_DIV, S_DIV_W, S_OUT
   } state_type;

   state_type         state_ff;
   dctb_pkg::req_type req_ff;
   logic [31:0]       def_on_ff, def_cyc_ff, now_ff;
   logic [1:0]        kind_ff [CHANNELS];
   logic [3:0]        floor_ff [CHANNELS];
   logic [CHANNELS-1:0] level_ff, enab_ff;
   logic [CW-1:0]     count_ff;
   logic [IW-1:0]     idx_ff;
   logic              found_ff;
   logic [1:0]        status_ff;
   logic [22:0]       value_ff;
   logic              rsp_valid_ff;
   logic [15:0]       states_out_ff;

   // Memories: on-time with cycle time in one word, and start mark.
   logic        times_we, mk_we;
   logic [63:0] times_wd, times_rd;
   logic [31:0] mk_wd, mk_rd, on_rd, cyc_rd;

   dctb_ram #(.Width(64), .Depth(CHANNELS)) u_times (.clock(clock), .wr_en(times_we),
      .wr_addr(idx_ff), .wr_data(times_wd), .rd_addr(idx_ff), .rd_data(times_rd));
   dctb_ram #(.Width(32), .Depth(CHANNELS)) u_mk (.clock(clock), .wr_en(mk_we),
      .wr_addr(idx_ff), .wr_data(mk_wd), .rd_addr(idx_ff), .rd_data(mk_rd));

   assign on_rd  = times_rd[63:32];
   assign cyc_rd = times_rd[31:0];

   logic        div_start, div_busy;
   logic [31:0] div_in;
   logic [22:0] div_q;

   dctb_div1000 u_div (.clock(clock), .reset(reset), .start(div_start),
      .dividend(div_in), .busy(div_busy), .quotient(div_q));

   logic [31:0] on_ms_req, cyc_ms_req, elapsed;
   logic        last_idx, cmd_sel;
   assign on_ms_req  = dctb_pkg::sec_to_ms(req_ff.on_seconds);
   assign cyc_ms_req = dctb_pkg::sec_to_ms(req_ff.cycle_seconds);
   assign elapsed    = now_ff - mk_rd;
   assign last_idx   = (CW'(idx_ff) + CW'(1) >= count_ff);
   assign cmd_sel    = (req_ff.command >= dctb_pkg::CMD_SET_ON) &&
                       (req_ff.command <= dctb_pkg::CMD_GET_EL);

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{status: status_ff, value_seconds: value_ff,
                        channel_states: states_out_ff};

   // Write strobes for the two memories, and the divider start and input.
   always_comb begin
      times_we = 1'b0; mk_we = 1'b0;
      times_wd = {on_ms_req, cyc_ms_req}; mk_wd = now_ff;
      div_start = 1'b0; div_in = on_rd;
      case (state_ff)
         S_OP_RD: begin
            if (req_ff.command == dctb_pkg::CMD_ADD) begin
               times_we = 1'b1; mk_we = 1'b1; mk_wd = 32'd0;
               if (req_ff.on_seconds >= req_ff.cycle_seconds) begin
                  times_wd = {def_on_ff, def_cyc_ff};
               end
            end else if (req_ff.command == dctb_pkg::CMD_BEGIN) begin
               mk_we = 1'b1;
            end
         end
         S_RUN_WR: begin
            mk_we = enab_ff[idx_ff] && !(elapsed < on_rd && !level_ff[idx_ff]) &&
                    !(elapsed >= on_rd && elapsed < cyc_rd && level_ff[idx_ff]) &&
                    (elapsed >= cyc_rd);
         end
         S_OP_WR: begin
            case (req_ff.command)
               dctb_pkg::CMD_SET_ON, dctb_pkg::CMD_SET_BOTH: begin
                  times_we = on_ms_req < cyc_rd;
                  times_wd = {on_ms_req, cyc_rd};
               end
               dctb_pkg::CMD_SET_CYC: begin
                  times_we = on_rd < cyc_ms_req;
                  times_wd = {on_rd, cyc_ms_req};
               end
               dctb_pkg::CMD_GET_ON: div_start = 1'b1;
               dctb_pkg::CMD_GET_CYC: begin
                  div_start = 1'b1; div_in = cyc_rd;
               end
               dctb_pkg::CMD_GET_EL: begin
                  div_start = 1'b1; div_in = elapsed;
               end
               default: ;
            endcase
         end
         S_OP2_W: begin
            times_we = on_rd < cyc_ms_req;
            times_wd = {on_rd, cyc_ms_req};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         def_on_ff <= 32'd1000;
         def_cyc_ff <= 32'd60000;
         now_ff <= 32'd0;
         level_ff <= '0;
         enab_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            kind_ff[i] <= 2'd0;
            floor_ff[i] <= 4'd0;
         end
      end else begin
         if (csr_write) begin
            if (csr_index == dctb_pkg::CSR_DEF_ON) def_on_ff <= csr_data;
            else def_cyc_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_data;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  status_ff <= dctb_pkg::ST_DONE;
                  value_ff <= 23'd0;
                  case (req_data.command)
                     dctb_pkg::CMD_TICK: begin
                        now_ff <= now_ff + 32'd1;
                        state_ff <= (count_ff == '0) ? S_OUT : S_RUN_RD;
                     end
                     dctb_pkg::CMD_ADD: begin
                        if (count_ff >= CW'(CHANNELS)) begin
                           status_ff <= dctb_pkg::ST_NOMATCH;
                           state_ff <= S_OUT;
                        end else begin
                           idx_ff <= IW'(count_ff);
                           state_ff <= S_OP_RD;
                        end
                     end
                     dctb_pkg::CMD_BEGIN:
                        state_ff <= (count_ff == '0) ? S_OUT : S_OP_RD;
                     dctb_pkg::CMD_SET_ON, dctb_pkg::CMD_SET_CYC,
                     dctb_pkg::CMD_SET_BOTH, dctb_pkg::CMD_ENABLE,
                     dctb_pkg::CMD_GET_ON, dctb_pkg::CMD_GET_CYC,
                     dctb_pkg::CMD_GET_EL: state_ff <= S_SRCH;
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_SRCH: begin
               // One table entry compared per cycle, first match wins.
               if (count_ff == '0 || CW'(idx_ff) >= count_ff) begin
                  status_ff <= dctb_pkg::ST_NOMATCH;
                  state_ff <= S_OUT;
               end else if (kind_ff[idx_ff] == req_ff.channel_type &&
                            floor_ff[idx_ff] == req_ff.floor_id) begin
                  found_ff <= 1'b1;
                  state_ff <= S_OP_RD;
               end else if (last_idx) begin
                  status_ff <= dctb_pkg::ST_NOMATCH;
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
            S_RUN_RD: state_ff <= S_RUN_W;
            S_RUN_W: state_ff <= S_RUN_WR;
            S_RUN_WR: begin
               if (enab_ff[idx_ff]) begin
                  if (elapsed < on_rd && !level_ff[idx_ff])
                     level_ff[idx_ff] <= 1'b1;
                  else if (elapsed >= on_rd && elapsed < cyc_rd && level_ff[idx_ff])
                     level_ff[idx_ff] <= 1'b0;
               end
               if (last_idx) state_ff <= S_OUT;
               else begin
                  idx_ff <= idx_ff + IW'(1);
                  state_ff <= S_RUN_RD;
               end
            end
            S_OP_RD: begin
               case (req_ff.command)
                  dctb_pkg::CMD_ADD: begin
                     kind_ff[idx_ff] <= req_ff.channel_type;
                     floor_ff[idx_ff] <= req_ff.floor_id;
                     level_ff[idx_ff] <= 1'b0;
                     enab_ff[idx_ff] <= 1'b0;
                     count_ff <= count_ff + CW'(1);
                     state_ff <= S_OUT;
                  end
                  dctb_pkg::CMD_BEGIN: begin
                     enab_ff[idx_ff] <= 1'b1;
                     if (last_idx) state_ff <= S_OUT;
                     else idx_ff <= idx_ff + IW'(1);
                  end
                  dctb_pkg::CMD_ENABLE: begin
                     enab_ff[idx_ff] <= req_ff.enable_flag;
                     state_ff <= S_OUT;
                  end
                  default: state_ff <= S_OP_W;
               endcase
            end
            S_OP_W: state_ff <= S_OP_WR;
            S_OP_WR: begin
               case (req_ff.command)
                  dctb_pkg::CMD_SET_ON: begin
                     if (!(on_ms_req < cyc_rd)) status_ff <= dctb_pkg::ST_REJECT;
                     state_ff <= S_OUT;
                  end
                  dctb_pkg::CMD_SET_CYC: begin
                     if (!(on_rd < cyc_ms_req)) status_ff <= dctb_pkg::ST_REJECT;
                     state_ff <= S_OUT;
                  end
                  dctb_pkg::CMD_SET_BOTH: begin
                     if (!(on_ms_req < cyc_rd)) status_ff <= dctb_pkg::ST_REJECT;
                     state_ff <= S_OP2_RD;
                  end
                  default: state_ff <= S_DIV;
               endcase
            end
            // Reread the on-time after the first half of set-both.
            S_OP2_RD: state_ff <= S_OP2_W;
            S_OP2_W: begin
               if (!(on_rd < cyc_ms_req)) status_ff <= dctb_pkg::ST_REJECT;
               state_ff <= S_OUT;
            end
            S_DIV: state_ff <= S_DIV_W;
            S_DIV_W: begin
               if (!div_busy) begin
                  value_ff <= div_q;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT) states_out_ff <= 16'(level_ff);
   end

   `ASSERT_CLK(a_no_accept_busy, clock, reset,
      (req_valid && !req_stall) |-> (state_ff == S_IDLE && !rsp_valid_ff),
      "item accepted while busy")
   `ASSERT_CLK(a_count_range, clock, reset,
      count_ff <= CW'(CHANNELS), "channel count overflow")
   `ASSERT_CLK(a_rsp_from_out, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT), "result without sequencer")
   `ASSERT_CLK(a_found_sel, clock, reset,
      (state_ff == S_OP_W) |-> (found_ff && cmd_sel), "operation without match")
endmodule
